// ----- src/ptd_pkg.sv -----
// Package for the periodic task dispatcher: slot count, field widths,
// command and result codes, payload structs and the sequencer state type.
// Depends on nothing; every module of the dispatcher imports it.
package ptd_pkg;

  localparam int TASK_COUNT  = 8;
  localparam int MAX_RESULTS = 8;

  localparam int IDX_W  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int CNT_W  = $clog2(TASK_COUNT + 1);
  localparam int REP_W  = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W = 3;
  localparam int CODE_W = 3;
  localparam int TIME_W = 16;

  localparam logic [CODE_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CODE_W-1:0] CMD_SUSPEND = 3'd1;
  localparam logic [CODE_W-1:0] CMD_RESUME  = 3'd2;
  localparam logic [CODE_W-1:0] CMD_DELETE  = 3'd3;
  localparam logic [CODE_W-1:0] CMD_TICK    = 3'd4;

  localparam logic [CODE_W-1:0] KIND_CREATE_OK     = 3'd0;
  localparam logic [CODE_W-1:0] KIND_CREATE_REJECT = 3'd1;
  localparam logic [CODE_W-1:0] KIND_DISPATCH      = 3'd2;
  localparam logic [CODE_W-1:0] KIND_IDLE_TICK     = 3'd3;
  localparam logic [CODE_W-1:0] KIND_ACK           = 3'd4;

  typedef struct packed {
    logic [CODE_W-1:0] command;
    logic [SLOT_W-1:0] task_req;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
  } ptd_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } ptd_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_FLUSH
  } ptd_state_t;

endpackage

// ----- src/periodic_task_dispatcher.sv -----
// Top level of the periodic task dispatcher: slot flags, period and
// countdown memories, and the tick sequencer that walks the slots.
// Depends on ptd_pkg.
//
// A create, suspend, resume or delete command is accepted while idle and its
// single result appears on the following cycle; busy stays low, so the next
// command may follow at once. A tick reads the countdown and period memories
// one slot per cycle, pipelined against the write-back of the slot before,
// and keeps busy high until the walk has ended and the flush state has passed.
// Each dispatch result is held back until the next due slot has been found or
// the walk has ended, so that the final one can carry last; the final result
// of a tick is sent from the flush state. A tick with nothing due gives one
// idle-tick result. Results are strobed by out_valid for one cycle and cannot
// be held off, so the receiver must take every transfer when it is presented.
module periodic_task_dispatcher
  import ptd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ptd_in_t  in_data,
  output logic     out_valid,
  output ptd_out_t out_data
);

  ptd_state_t state_r, state_nxt;

  logic [TASK_COUNT-1:0] occupied_r, occupied_nxt;
  logic [TASK_COUNT-1:0] running_r, running_nxt;
  logic [TASK_COUNT-1:0] cd_vld_r, cd_vld_nxt;

  logic [TIME_W-1:0] period_mem [TASK_COUNT];
  logic [TIME_W-1:0] cd_mem [TASK_COUNT];
  logic [TIME_W-1:0] per_q, cd_q;

  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              pv_r, pv_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [REP_W-1:0]  rep_cnt_r, rep_cnt_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [SLOT_W-1:0] pend_slot_r, pend_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  ptd_out_t          out_data_r, out_data_nxt;

  logic              accept;
  logic              req_ok;
  logic [IDX_W-1:0]  req_idx;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              last_proc;
  logic [TIME_W-1:0] cd_cur;
  logic              due;
  logic              wb_en;
  logic [TIME_W-1:0] wb_data;
  logic              create_wr;
  logic              cd_wr_en;
  logic [IDX_W-1:0]  cd_wr_addr;
  logic [TIME_W-1:0] cd_wr_data;

  assign accept  = start && !busy;
  assign req_ok  = int'(in_data.task_req) < TASK_COUNT;
  assign req_idx = IDX_W'(in_data.task_req);
  assign rd_addr = rd_idx_r[IDX_W-1:0];
  assign last_proc = pv_r && (pidx_r == IDX_W'(TASK_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.command == CMD_TICK) begin
          state_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        if (last_proc) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_TICK:  rd_en = int'(rd_idx_r) < TASK_COUNT;
      ST_FLUSH: busy = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_comb begin
    cd_cur  = cd_vld_r[pidx_r] ? cd_q : '0;
    due     = pv_r && running_r[pidx_r] && occupied_r[pidx_r] && (cd_cur == '0);
    wb_en   = pv_r && running_r[pidx_r] && ((cd_cur != '0) || occupied_r[pidx_r]);
    wb_data = (cd_cur == '0) ? per_q - 1'b1 : cd_cur - 1'b1;
  end

  always_comb begin
    occupied_nxt  = occupied_r;
    running_nxt   = running_r;
    cd_vld_nxt    = cd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    pv_nxt        = rd_en;
    pidx_nxt      = rd_addr;
    rep_cnt_nxt   = rep_cnt_r;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    create_wr     = 1'b0;

    if (rd_en) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end

    if (accept) begin
      out_data_nxt.slot = in_data.task_req;
      out_data_nxt.last = 1'b1;
      out_data_nxt.kind = KIND_ACK;
      case (in_data.command)
        CMD_CREATE: begin
          out_valid_nxt = 1'b1;
          if (req_ok && !occupied_r[req_idx]) begin
            create_wr             = 1'b1;
            occupied_nxt[req_idx] = 1'b1;
            running_nxt[req_idx]  = 1'b1;
            cd_vld_nxt[req_idx]   = 1'b1;
            out_data_nxt.kind     = KIND_CREATE_OK;
          end else begin
            out_data_nxt.kind = KIND_CREATE_REJECT;
          end
        end
        CMD_SUSPEND: begin
          out_valid_nxt = 1'b1;
          if (req_ok) begin
            running_nxt[req_idx] = 1'b0;
          end
        end
        CMD_RESUME: begin
          out_valid_nxt = 1'b1;
          if (req_ok) begin
            running_nxt[req_idx] = 1'b1;
          end
        end
        CMD_DELETE: begin
          out_valid_nxt = 1'b1;
          if (req_ok) begin
            occupied_nxt[req_idx] = 1'b0;
          end
        end
        CMD_TICK: begin
          rd_idx_nxt   = '0;
          rep_cnt_nxt  = '0;
          pend_vld_nxt = 1'b0;
        end
        default: out_valid_nxt = 1'b0;
      endcase
    end

    if (due && (int'(rep_cnt_r) < MAX_RESULTS)) begin
      rep_cnt_nxt   = rep_cnt_r + 1'b1;
      pend_vld_nxt  = 1'b1;
      pend_slot_nxt = SLOT_W'(pidx_r);
      if (pend_vld_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{kind: KIND_DISPATCH, slot: pend_slot_r, last: 1'b0};
      end
    end

    if (state_r == ST_FLUSH) begin
      out_valid_nxt = 1'b1;
      pend_vld_nxt  = 1'b0;
      if (pend_vld_r) begin
        out_data_nxt = '{kind: KIND_DISPATCH, slot: pend_slot_r, last: 1'b1};
      end else begin
        out_data_nxt = '{kind: KIND_IDLE_TICK, slot: '0, last: 1'b1};
      end
    end
  end

  always_comb begin
    cd_wr_en   = create_wr || wb_en;
    cd_wr_addr = create_wr ? req_idx : pidx_r;
    cd_wr_data = create_wr ? in_data.first_delay : wb_data;
  end

  always_ff @(posedge clk) begin
    if (create_wr) begin
      period_mem[req_idx] <= in_data.period;
    end
    if (cd_wr_en) begin
      cd_mem[cd_wr_addr] <= cd_wr_data;
    end
    if (rd_en) begin
      per_q <= period_mem[rd_addr];
      cd_q  <= cd_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occupied_r  <= '0;
      running_r   <= '0;
      cd_vld_r    <= '0;
      rd_idx_r    <= '0;
      pv_r        <= 1'b0;
      rep_cnt_r   <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occupied_r  <= occupied_nxt;
      running_r   <= running_nxt;
      cd_vld_r    <= cd_vld_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pv_r        <= pv_nxt;
      rep_cnt_r   <= rep_cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r      <= pidx_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cmd_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.command == CMD_CREATE || in_data.command == CMD_SUSPEND ||
                in_data.command == CMD_RESUME || in_data.command == CMD_DELETE))
    |=> (out_valid && out_data.last))
    else $error("A slot command did not give a single final result.");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.command == CMD_TICK) |=> busy)
    else $error("A tick transfer did not start the slot walk.");

  a_no_stale_pend: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !pend_vld_r)
    else $error("A dispatch result was left pending after a tick.");

  a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_IDLE_TICK)
    |-> (out_data.slot == '0 && out_data.last))
    else $error("An idle-tick result carried a slot or was not final.");

endmodule

// ----- tb/periodic_task_dispatcher_test.sv -----
`timescale 1ns / 100ps
// Testbench for the periodic task dispatcher: a directed table, then random
// command streams, checked against a row's result or a slot-table predictor.
// Depends on ptd_pkg and periodic_task_dispatcher.
module periodic_task_dispatcher_test
  import ptd_pkg::*;
();

  localparam logic [CODE_W-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [CODE_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CODE_W-1:0] CMD_RSVD_HI  = 3'd7;
  localparam int RANDOM_ITEMS = 385;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 19;

  typedef struct {
    ptd_in_t  stim;
    int       typed_n;
    ptd_out_t typed;
  } directed_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ptd_in_t  in_data;
  logic     out_valid;
  ptd_out_t out_data;

  bit              slot_used      [TASK_COUNT];
  bit              slot_running   [TASK_COUNT];
  bit [TIME_W-1:0] slot_period    [TASK_COUNT];
  bit [TIME_W-1:0] slot_countdown [TASK_COUNT];

  ptd_out_t      expected_results[$];
  ptd_out_t      predicted[$];
  directed_row_t directed_rows[$];
  int            typed_n_cur;
  ptd_out_t      typed_cur;
  ptd_out_t      oldest;
  int            mismatches;
  int            stall_cycles;

  periodic_task_dispatcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic ptd_out_t mk_result(logic [CODE_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                         logic last);
    ptd_out_t r;
    r.kind = kind;
    r.slot = slot;
    r.last = last;
    return r;
  endfunction

  function automatic directed_row_t mk_row(logic [CODE_W-1:0] cmd, int req, int per, int dly,
                                           int typed_n, logic [CODE_W-1:0] kind, int slot);
    directed_row_t row;
    row.stim.command     = cmd;
    row.stim.task_req    = req[SLOT_W-1:0];
    row.stim.period      = per[TIME_W-1:0];
    row.stim.first_delay = dly[TIME_W-1:0];
    row.typed_n          = typed_n;
    row.typed            = mk_result(kind, slot[SLOT_W-1:0], 1'b1);
    return row;
  endfunction

  // Advances the slot table by one command and leaves its results in predicted.
  function void schedule_step(input ptd_in_t cmd);
    ptd_out_t res;
    int       n;
    bit       known;
    int       s;
    predicted.delete();
    known = int'(cmd.task_req) < TASK_COUNT;
    s = known ? int'(cmd.task_req) : 0;
    case (cmd.command)
      CMD_CREATE: begin
        if (known && !slot_used[s]) begin
          slot_used[s]      = 1'b1;
          slot_running[s]   = 1'b1;
          slot_period[s]    = cmd.period;
          slot_countdown[s] = cmd.first_delay;
          predicted.push_back(mk_result(KIND_CREATE_OK, cmd.task_req, 1'b1));
        end else begin
          predicted.push_back(mk_result(KIND_CREATE_REJECT, cmd.task_req, 1'b1));
        end
      end
      CMD_SUSPEND: begin
        if (known) slot_running[s] = 1'b0;
        predicted.push_back(mk_result(KIND_ACK, cmd.task_req, 1'b1));
      end
      CMD_RESUME: begin
        if (known) slot_running[s] = 1'b1;
        predicted.push_back(mk_result(KIND_ACK, cmd.task_req, 1'b1));
      end
      CMD_DELETE: begin
        if (known) slot_used[s] = 1'b0;
        predicted.push_back(mk_result(KIND_ACK, cmd.task_req, 1'b1));
      end
      CMD_TICK: begin
        n = 0;
        for (int i = 0; i < TASK_COUNT; i++) begin
          if (slot_running[i]) begin
            if (slot_countdown[i] == '0) begin
              if (slot_used[i]) begin
                if (n < MAX_RESULTS) begin
                  predicted.push_back(mk_result(KIND_DISPATCH, i[SLOT_W-1:0], 1'b0));
                  n++;
                end
                slot_countdown[i] = slot_period[i] - 16'd1;
              end
            end else begin
              slot_countdown[i] = slot_countdown[i] - 16'd1;
            end
          end
        end
        if (n == 0) begin
          predicted.push_back(mk_result(KIND_IDLE_TICK, '0, 1'b1));
        end else begin
          res = predicted.pop_back();
          res.last = 1'b1;
          predicted.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic ptd_in_t random_command();
    ptd_in_t item;
    int      pick;
    pick = $urandom_range(99);
    item.task_req    = SLOT_W'($urandom_range(TASK_COUNT - 1));
    item.period      = TIME_W'($urandom);
    item.first_delay = TIME_W'($urandom);
    if (pick < 38) begin
      item.command = CMD_TICK;
    end else if (pick < 63) begin
      item.command = CMD_CREATE;
      if ($urandom_range(3) != 0) item.period = TIME_W'($urandom_range(4));
      if ($urandom_range(3) != 0) item.first_delay = TIME_W'($urandom_range(6));
    end else if (pick < 71) begin
      item.command = CMD_SUSPEND;
    end else if (pick < 81) begin
      item.command = CMD_RESUME;
    end else if (pick < 93) begin
      item.command = CMD_DELETE;
    end else begin
      item.command = CMD_RSVD_LO + CODE_W'($urandom_range(2));
    end
    return item;
  endfunction

  task automatic idle_gap(input bit allow);
    while (allow && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic send_item(input ptd_in_t item, input int typed_n, input ptd_out_t typed);
    @(negedge clk);
    start       <= 1'b1;
    in_data     <= item;
    typed_n_cur <= typed_n;
    typed_cur   <= typed;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: kind=%0d slot=%0d last=%0d",
                     out_data.kind, out_data.slot, out_data.last);
        end else begin
          oldest = expected_results.pop_front();
          if (out_data.kind !== oldest.kind || out_data.slot !== oldest.slot ||
              out_data.last !== oldest.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: exp kind=%0d slot=%0d last=%0d, got kind=%0d slot=%0d last=%0d",
                       oldest.kind, oldest.slot, oldest.last,
                       out_data.kind, out_data.slot, out_data.last);
          end
        end
      end
      if (start && !busy) begin
        schedule_step(in_data);
        if (typed_n_cur < 0) begin
          foreach (predicted[i]) expected_results.push_back(predicted[i]);
        end else if (typed_n_cur > 0) begin
          expected_results.push_back(typed_cur);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    ptd_in_t item;
    int      counted;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    typed_n_cur  = -1;
    typed_cur    = '0;
    mismatches   = 0;
    stall_cycles = 0;

    directed_rows.push_back(mk_row(CMD_TICK,     0, 0, 0,  1, KIND_IDLE_TICK, 0));
    directed_rows.push_back(mk_row(CMD_SUSPEND,  7, 0, 0,  1, KIND_ACK, 7));
    directed_rows.push_back(mk_row(CMD_RESUME,   0, 0, 0,  1, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_DELETE,   3, 0, 0,  1, KIND_ACK, 3));
    directed_rows.push_back(mk_row(CMD_TICK,     0, 0, 0, -1, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_CREATE,   0, 0, 0,  1, KIND_CREATE_OK, 0));
    directed_rows.push_back(mk_row(CMD_CREATE,   0, 5, 5,  1, KIND_CREATE_REJECT, 0));
    directed_rows.push_back(mk_row(CMD_CREATE,   7, 65535, 65535, 1, KIND_CREATE_OK, 7));
    directed_rows.push_back(mk_row(CMD_CREATE,   3, 1, 2,  1, KIND_CREATE_OK, 3));
    directed_rows.push_back(mk_row(CMD_CREATE,   5, 3, 0,  1, KIND_CREATE_OK, 5));
    directed_rows.push_back(mk_row(CMD_TICK,     0, 0, 0, -1, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_TICK,     6, 65535, 65535, -1, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_RSVD_LO,  2, 9, 9,  0, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_RSVD_MID, 5, 0, 0,  0, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_RSVD_HI,  7, 65535, 65535, 0, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_SUSPEND,  3, 0, 0,  1, KIND_ACK, 3));
    directed_rows.push_back(mk_row(CMD_TICK,     0, 0, 0, -1, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_RESUME,   3, 0, 0,  1, KIND_ACK, 3));
    directed_rows.push_back(mk_row(CMD_DELETE,   0, 0, 0,  1, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_CREATE,   1, 2, 0,  1, KIND_CREATE_OK, 1));
    directed_rows.push_back(mk_row(CMD_CREATE,   2, 1, 0,  1, KIND_CREATE_OK, 2));
    directed_rows.push_back(mk_row(CMD_CREATE,   4, 2, 0,  1, KIND_CREATE_OK, 4));
    directed_rows.push_back(mk_row(CMD_CREATE,   6, 1, 0,  1, KIND_CREATE_OK, 6));
    directed_rows.push_back(mk_row(CMD_TICK,     0, 0, 0, -1, KIND_ACK, 0));
    directed_rows.push_back(mk_row(CMD_TICK,     0, 0, 0, -1, KIND_ACK, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      idle_gap(1'b1);
      send_item(directed_rows[i].stim, directed_rows[i].typed_n, directed_rows[i].typed);
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      item = random_command();
      idle_gap(counted < 150 || counted >= 260);
      send_item(item, -1, '0);
      counted++;
    end
    @(negedge clk);
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("Results never arrived: %0d", expected_results.size());
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ptd_pkg.sv
src/periodic_task_dispatcher.sv
tb/periodic_task_dispatcher_test.sv
